/* design/acrk_pkg.sv */
`default_nettype none
package acrk_pkg;

    localparam logic [2:0] MODE_CHILL    = 3'd0;
    localparam logic [2:0] MODE_ADAPTIVE = 3'd2;
    localparam logic [2:0] MODE_LAST     = 3'd4;

    localparam logic [1:0] FAN_SPEED_AUTO = 2'd3;

    localparam logic [5:0]  TEMP_RESET    = 6'd26;
    localparam logic [6:0]  TIMER_RESET   = 7'd10;
    localparam logic [16:0] MS_PER_SECOND = 17'd1000;

    // configuration register indexes
    localparam logic [2:0] CFG_LONG_PRESS    = 3'd0;
    localparam logic [2:0] CFG_BLINK         = 3'd1;
    localparam logic [2:0] CFG_TEMP_MIN      = 3'd2;
    localparam logic [2:0] CFG_TEMP_MAX      = 3'd3;
    localparam logic [2:0] CFG_TIMER_DEFAULT = 3'd4;
    localparam logic [2:0] CFG_TIMER_MAX     = 3'd5;

    localparam logic [15:0] LONG_PRESS_RESET    = 16'd1000;
    localparam logic [15:0] BLINK_RESET         = 16'd250;
    localparam logic [5:0]  TEMP_MIN_RESET      = 6'd16;
    localparam logic [5:0]  TEMP_MAX_RESET      = 6'd30;
    localparam logic [6:0]  TIMER_DEFAULT_RESET = 7'd10;
    localparam logic [6:0]  TIMER_MAX_RESET     = 7'd99;

    typedef struct packed {
        logic [15:0] hold_ms;
        logic [15:0] blink_ms;
        logic [5:0]  temp_min;
        logic [5:0]  temp_max;
        logic [6:0]  timer_default_s;
        logic [6:0]  timer_max_s;
    } t_cfg;

    typedef struct packed {
        logic mode_timer;
        logic temp_up;
        logic temp_down;
        logic fan_power;
    } t_keys;

    typedef struct packed {
        logic        power;
        logic [2:0]  mode;
        logic [2:0]  rem_mode;
        logic [5:0]  temp;
        logic [1:0]  fan;
        logic [3:0]  held;
        logic [31:0] fan_start;
        logic [31:0] mode_start;
        logic        fan_long_done;
        logic        mode_long_done;
        logic        setup;
        logic        cd_active;
        logic [6:0]  cd_len;
        logic [31:0] cd_start;
        logic        led_lit;
        logic [31:0] led_start;
    } t_state;

    localparam t_state STATE_RESET = '{
        power:          1'b0,
        mode:           MODE_CHILL,
        rem_mode:       MODE_CHILL,
        temp:           TEMP_RESET,
        fan:            FAN_SPEED_AUTO,
        held:           4'd0,
        fan_start:      32'd0,
        mode_start:     32'd0,
        fan_long_done:  1'b0,
        mode_long_done: 1'b0,
        setup:          1'b0,
        cd_active:      1'b0,
        cd_len:         TIMER_RESET,
        cd_start:       32'd0,
        led_lit:        1'b0,
        led_start:      32'd0
    };

    typedef struct packed {
        logic [7:0] timer_frame_byte;
        logic [7:0] control_byte;
        logic       send_request;
        logic       blink_led;
        logic       key_beep;
        logic [6:0] countdown_seconds;
        logic       countdown_running;
        logic       in_timer_setup;
        logic [5:0] set_temp;
        logic [1:0] fan_speed;
        logic [2:0] mode;
        logic       power_on;
    } t_result;

endpackage
`default_nettype wire

/* design/acrk_step.sv */
`default_nettype none
module acrk_step
    import acrk_pkg::*;
(
    input  wire t_cfg    i_cfg,
    input  wire t_state  i_state,
    input  wire t_keys   i_keys,
    input  wire [31:0]   i_now,
    output t_state       o_state,
    output t_result      o_result
);

    t_state      ns;
    logic        any_key;
    logic        send;
    logic [16:0] len_ms;

    always_comb begin
        ns      = i_state;
        any_key = 1'b0;
        send    = 1'b0;

        if (i_state.setup) begin
            // temperature keys step the seconds on press
            if (i_keys.temp_down) begin
                any_key = 1'b1;
                if (!ns.held[1]) begin
                    ns.held[1] = 1'b1;
                    if (ns.cd_len > 7'd1) begin
                        ns.cd_len    = ns.cd_len - 7'd1;
                        ns.led_lit   = 1'b1;
                        ns.led_start = i_now;
                    end
                end
            end else begin
                ns.held[1] = 1'b0;
            end
            if (i_keys.temp_up) begin
                any_key = 1'b1;
                if (!ns.held[2]) begin
                    ns.held[2] = 1'b1;
                    if (ns.cd_len < i_cfg.timer_max_s) begin
                        ns.cd_len    = ns.cd_len + 7'd1;
                        ns.led_lit   = 1'b1;
                        ns.led_start = i_now;
                    end
                end
            end else begin
                ns.held[2] = 1'b0;
            end
            if (i_keys.mode_timer) begin
                any_key = 1'b1;
                if (!ns.held[3]) begin
                    ns.held[3]        = 1'b1;
                    ns.mode_start     = i_now;
                    ns.mode_long_done = 1'b0;
                end
                if (!ns.mode_long_done &&
                    (32'(i_now - ns.mode_start) >= 32'(i_cfg.hold_ms))) begin
                    // long hold cancels
                    ns.mode_long_done = 1'b1;
                    ns.setup          = 1'b0;
                    ns.cd_active      = 1'b0;
                    ns.led_lit        = 1'b1;
                    ns.led_start      = i_now;
                    send              = 1'b1;
                end
            end else begin
                if (ns.held[3] && !ns.mode_long_done) begin
                    // short release confirms
                    ns.setup     = 1'b0;
                    ns.cd_active = 1'b1;
                    ns.cd_start  = i_now;
                    ns.led_lit   = 1'b1;
                    ns.led_start = i_now;
                    send         = 1'b1;
                end
                ns.held[3] = 1'b0;
            end
        end else begin
            if (i_keys.fan_power) begin
                any_key = 1'b1;
                if (!ns.held[0]) begin
                    ns.held[0]       = 1'b1;
                    ns.fan_start     = i_now;
                    ns.fan_long_done = 1'b0;
                end
                if (!ns.fan_long_done &&
                    (32'(i_now - ns.fan_start) >= 32'(i_cfg.hold_ms))) begin
                    ns.fan_long_done = 1'b1;
                    ns.power         = ~ns.power;
                    if (ns.power) begin
                        ns.mode = ns.rem_mode;
                    end
                    ns.cd_active = 1'b0;
                    ns.led_lit   = 1'b1;
                    ns.led_start = i_now;
                    send         = 1'b1;
                end
            end else begin
                if (ns.held[0] && !ns.fan_long_done && ns.power) begin
                    ns.fan       = ns.fan + 2'd1;
                    ns.led_lit   = 1'b1;
                    ns.led_start = i_now;
                    send         = 1'b1;
                end
                ns.held[0] = 1'b0;
            end
            // temperature keys act on release
            if (i_keys.temp_down) begin
                any_key    = 1'b1;
                ns.held[1] = 1'b1;
            end else if (ns.held[1]) begin
                if (ns.power && (ns.mode != MODE_ADAPTIVE) && (ns.temp > i_cfg.temp_min)) begin
                    ns.temp      = ns.temp - 6'd1;
                    ns.led_lit   = 1'b1;
                    ns.led_start = i_now;
                    send         = 1'b1;
                end
                ns.held[1] = 1'b0;
            end
            if (i_keys.temp_up) begin
                any_key    = 1'b1;
                ns.held[2] = 1'b1;
            end else if (ns.held[2]) begin
                if (ns.power && (ns.mode != MODE_ADAPTIVE) && (ns.temp < i_cfg.temp_max)) begin
                    ns.temp      = ns.temp + 6'd1;
                    ns.led_lit   = 1'b1;
                    ns.led_start = i_now;
                    send         = 1'b1;
                end
                ns.held[2] = 1'b0;
            end
            if (i_keys.mode_timer) begin
                any_key = 1'b1;
                if (!ns.held[3]) begin
                    ns.held[3]        = 1'b1;
                    ns.mode_start     = i_now;
                    ns.mode_long_done = 1'b0;
                end
                if (!ns.mode_long_done &&
                    (32'(i_now - ns.mode_start) >= 32'(i_cfg.hold_ms))) begin
                    // long hold opens the timer setup screen
                    ns.mode_long_done = 1'b1;
                    ns.setup          = 1'b1;
                    ns.cd_active      = 1'b0;
                    ns.cd_len         = i_cfg.timer_default_s;
                    ns.held[1]        = 1'b0;
                    ns.held[2]        = 1'b0;
                    ns.led_lit        = 1'b1;
                    ns.led_start      = i_now;
                end
            end else begin
                if (ns.held[3] && !ns.mode_long_done && ns.power) begin
                    ns.mode      = (ns.mode >= MODE_LAST) ? MODE_CHILL : ns.mode + 3'd1;
                    ns.rem_mode  = ns.mode;
                    ns.led_lit   = 1'b1;
                    ns.led_start = i_now;
                    send         = 1'b1;
                end
                ns.held[3] = 1'b0;
            end
        end

        if (ns.led_lit && (32'(i_now - ns.led_start) >= 32'(i_cfg.blink_ms))) begin
            ns.led_lit = 1'b0;
        end

        // whole seconds elapsed >= len  is the same as  ms elapsed >= len * 1000
        len_ms = 17'(ns.cd_len) * MS_PER_SECOND;
        if (ns.cd_active && (32'(i_now - ns.cd_start) >= 32'(len_ms))) begin
            ns.cd_active = 1'b0;
            ns.power     = ~ns.power;
            if (ns.power) begin
                ns.mode = ns.rem_mode;
            end
            ns.led_lit   = 1'b1;
            ns.led_start = i_now;
            send         = 1'b1;
        end
    end

    assign o_state = ns;

    always_comb begin
        o_result.power_on          = ns.power;
        o_result.mode              = ns.mode;
        o_result.fan_speed         = ns.fan;
        o_result.set_temp          = ns.temp;
        o_result.in_timer_setup    = ns.setup;
        o_result.countdown_running = ns.cd_active;
        o_result.countdown_seconds = ns.cd_len;
        o_result.key_beep          = any_key;
        o_result.blink_led         = ns.led_lit;
        o_result.send_request      = send;
        o_result.control_byte      = {ns.power, ns.mode, ns.fan, ns.cd_active, 1'b0};
        o_result.timer_frame_byte  = ns.cd_active ? {1'b0, ns.cd_len} : 8'd0;
    end

endmodule
`default_nettype wire

/* design/ac_remote_key_controller.sv */
`default_nettype none
// Air-conditioner remote key controller. Each slave beat is one key scan; every scan gives
// exactly one master beat with the unit settings, buzzer, feedback LED, send request and the
// packed IR control and timer bytes, taken from the state after that scan. A scan is captured
// in an input register, and the whole state update is done combinationally between that register
// and the result register, which drives the master beat. A scan is accepted in every clock cycle
// while the master side is ready, so the sustained rate is one beat per clock, limited only by the
// update of the settings registers. Back-pressure on the master side holds the result register;
// the input register takes one more scan while the result waits only if it was empty.
// Configuration writes are accepted at any time (ready is always high) but are meant to be
// made while no scan is in flight; indexes beyond the last register are ignored.
module ac_remote_key_controller
    import acrk_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // tdata: fan_power_key[0], temp_down_key[1], temp_up_key[2], mode_timer_key[3],
    //        now_ms[35:4], zero[39:36]
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [39:0] s_axis_tdata,
    // tdata: power_on[0], mode[3:1], fan_speed[5:4], set_temp[11:6], in_timer_setup[12],
    //        countdown_running[13], countdown_seconds[20:14], key_beep[21], blink_led[22],
    //        send_request[23], control_byte[31:24], timer_frame_byte[39:32]
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;

    logic        r_in_valid;
    t_keys       r_keys;
    logic [31:0] r_now;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        advance;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    acrk_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_keys   (r_keys),
        .i_now    (r_now),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // scan payload and result payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_keys <= s_axis_tdata[3:0];
            r_now  <= s_axis_tdata[35:4];
        end
        if (advance && r_in_valid) begin
            r_out_data <= {n_result.timer_frame_byte, n_result.control_byte,
                           n_result.send_request, n_result.blink_led, n_result.key_beep,
                           n_result.countdown_seconds, n_result.countdown_running,
                           n_result.in_timer_setup, n_result.set_temp, n_result.fan_speed,
                           n_result.mode, n_result.power_on};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ms         <= LONG_PRESS_RESET;
            r_cfg.blink_ms        <= BLINK_RESET;
            r_cfg.temp_min        <= TEMP_MIN_RESET;
            r_cfg.temp_max        <= TEMP_MAX_RESET;
            r_cfg.timer_default_s <= TIMER_DEFAULT_RESET;
            r_cfg.timer_max_s     <= TIMER_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS:    r_cfg.hold_ms         <= i_cfg_data;
                CFG_BLINK:         r_cfg.blink_ms        <= i_cfg_data;
                CFG_TEMP_MIN:      r_cfg.temp_min        <= i_cfg_data[5:0];
                CFG_TEMP_MAX:      r_cfg.temp_max        <= i_cfg_data[5:0];
                CFG_TIMER_DEFAULT: r_cfg.timer_default_s <= i_cfg_data[6:0];
                CFG_TIMER_MAX:     r_cfg.timer_max_s     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/acrk_checker.sv */
`default_nettype none
module acrk_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);

    // result held steady while the master side stalls
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a free sink never blocks the next scan
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("scan blocked while the result side is ready");

    // ir bytes agree with the individual settings fields
    a_bytes_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[31] == m_axis_tdata[0]) &&
            (m_axis_tdata[30:28] == m_axis_tdata[3:1]) &&
            (m_axis_tdata[27:26] == m_axis_tdata[5:4]) &&
            (m_axis_tdata[25] == m_axis_tdata[13]) && !m_axis_tdata[24] &&
            (m_axis_tdata[39:32] == (m_axis_tdata[13] ? {1'b0, m_axis_tdata[20:14]} : 8'd0)))
        else $error("ir bytes disagree with settings");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= 3'd4))
        else $error("mode code out of range");

endmodule

bind ac_remote_key_controller acrk_checker u_acrk_checker (.*);
`default_nettype wire
